>>> src/icmprw_pkg.sv
// Shared types, constants and checksum helper for the ICMP echo reply rewriter.
package icmprw_pkg;

  // Values of the command field
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'h08;
  localparam logic [7:0] ICMP_ECHO_REPLY   = 8'h00;
  localparam logic [5:0] IPV4_MIN_HDR_LEN  = 6'd20;

  // Byte offsets inside the packet
  localparam int unsigned OFS_IP_CSUM_HI   = 10;
  localparam int unsigned OFS_IP_CSUM_LO   = 11;
  localparam int unsigned OFS_SRC_ADDR     = 12;
  localparam int unsigned OFS_DST_ADDR     = 16;
  localparam int unsigned OFS_ICMP_TYPE    = 20;
  localparam int unsigned OFS_ICMP_CSUM_HI = 22;
  localparam int unsigned OFS_ICMP_CSUM_LO = 23;
  localparam int unsigned ADDR_BYTES       = 4;
  localparam int unsigned ECHO_MIN_LEN     = 28;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } ctrl_state_e;

  typedef enum logic {
    SEL_STORE,
    SEL_CONST
  } byte_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic pull;
    logic capture;
  } ctrl_cmd_t;

  // One's-complement add of a 16-bit word with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

>>> src/icmp_echo_reply_rewriter.sv
// Top level of the ICMP echo reply rewriter: controller, datapath and packet store.
//
//  channel  signals                         direction  transaction
//  in       in_valid_i / in_ready_o         input      load one byte or pull one byte
//  res      res_valid_o / res_ready_i       output     one result per pull
//
// Loads can be accepted back to back.
// A pull's result passes through the registered store read, then the result
// register; the next item is taken as that result leaves.
// Reset clears all packet state; store contents are undefined until loaded.
// A result held by res_ready_i low blocks the input; the next load or pull is
// taken in the cycle the result is accepted.
module icmp_echo_reply_rewriter import icmprw_pkg::*; #(
  parameter int unsigned MAX_PACKET = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       is_ipv4_i,
  input  logic [5:0] header_len_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       rewritten_o,
  output logic       truncated_o
);

  ctrl_cmd_t cmd;

  icmprw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .res_ready_i (res_ready_i),
    .in_ready_o  (in_ready_o),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd)
  );

  icmprw_dp #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .is_ipv4_i    (is_ipv4_i),
    .header_len_i (header_len_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .rewritten_o  (rewritten_o),
    .truncated_o  (truncated_o)
  );

endmodule

>>> src/icmprw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module icmprw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/icmprw_ctrl.sv
// Controller: sequences load and pull transactions and the result handshake.
module icmprw_ctrl import icmprw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       command_i,
  input  logic       res_ready_i,
  output logic       in_ready_o,
  output logic       res_valid_o,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        in_ready_o  = res_ready_i;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a new transaction can start in the same cycle the result leaves
    if (in_valid_i && in_ready_o) begin
      if (command_i == CMD_PULL) begin
        cmd_o.pull = 1'b1;
        state_d    = ST_READ;
      end else begin
        cmd_o.load = 1'b1;
      end
    end
  end

  ap_pull_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_PULL) |=> ##1 res_valid_o)
    else $error("pull did not produce a result two cycles later");

  ap_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_LOAD) |=> !res_valid_o)
    else $error("load left a result pending");

  ap_capture_before_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (res_valid_o && !in_ready_o) || (res_valid_o && res_ready_i))
    else $error("capture not followed by result");

  ap_excl_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && (cmd_o.pull || cmd_o.load)))
    else $error("capture overlaps a new transaction");

endmodule

>>> src/icmprw_dp.sv
// Datapath: packet store, running checksums, flags and the read-out rewrite.
module icmprw_dp import icmprw_pkg::*; #(
  parameter int unsigned MAX_PACKET = 2048,
  localparam int unsigned AW = $clog2(MAX_PACKET),
  localparam int unsigned CW = $clog2(MAX_PACKET + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       is_ipv4_i,
  input  logic [5:0] header_len_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       rewritten_o,
  output logic       truncated_o
);

  localparam logic [CW-1:0] MaxCount = CW'(MAX_PACKET);

  // packet state
  logic [CW-1:0] byte_count_q, byte_count_d;
  logic [CW-1:0] read_index_q, read_index_d;
  logic [15:0]   hdr_sum_q, hdr_sum_d;
  logic [15:0]   icmp_sum_q, icmp_sum_d;
  logic          v4_q, v4_d, h20_q, h20_d, trunc_q, trunc_d, done_q, done_d;
  logic          emitting_q, emitting_d;
  logic [7:0]    type_byte_q;

  // pull transaction held for the read cycle
  logic          p_hit_q, p_last_q, p_rw_q, p_trunc_q;
  byte_sel_e     p_sel_q;
  logic [7:0]    p_const_q;

  // result register
  logic          o_valid_q, o_last_q, o_rw_q, o_trunc_q;
  logic [7:0]    o_byte_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  logic          clr, hit, rw, is_last;
  logic [CW-1:0] ld_idx;
  logic [15:0]   ld_word;
  byte_sel_e     sel;
  logic [7:0]    const_byte;
  logic [15:0]   hdr_csum, icmp_csum;

  icmprw_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PACKET)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign hdr_csum  = ~hdr_sum_q;
  assign icmp_csum = ~icmp_sum_q;

  assign rw = v4_q && h20_q && !trunc_q && (byte_count_q >= CW'(ECHO_MIN_LEN)) &&
              (type_byte_q == ICMP_ECHO_REQUEST);
  assign hit     = done_q && (read_index_q < byte_count_q);
  assign is_last = (read_index_q + CW'(1)) == byte_count_q;

  // a load after a complete packet or during read-out starts over
  assign clr     = done_q || emitting_q;
  assign ld_idx  = clr ? '0 : byte_count_q;
  assign ld_word = ld_idx[0] ? {8'h00, data_byte_i} : {data_byte_i, 8'h00};

  assign ram_we    = cmd_i.load && (ld_idx < MaxCount);
  assign ram_waddr = ld_idx[AW-1:0];

  // read address with source/destination swap, and inserted bytes
  always_comb begin
    ram_raddr  = read_index_q[AW-1:0];
    sel        = SEL_STORE;
    const_byte = 8'h00;
    if (rw) begin
      if (read_index_q >= CW'(OFS_SRC_ADDR) && read_index_q < CW'(OFS_DST_ADDR)) begin
        ram_raddr = AW'(read_index_q + CW'(ADDR_BYTES));
      end else if (read_index_q >= CW'(OFS_DST_ADDR) &&
                   read_index_q < CW'(OFS_ICMP_TYPE)) begin
        ram_raddr = AW'(read_index_q - CW'(ADDR_BYTES));
      end
      if (read_index_q == CW'(OFS_IP_CSUM_HI)) begin
        sel = SEL_CONST; const_byte = hdr_csum[15:8];
      end else if (read_index_q == CW'(OFS_IP_CSUM_LO)) begin
        sel = SEL_CONST; const_byte = hdr_csum[7:0];
      end else if (read_index_q == CW'(OFS_ICMP_TYPE)) begin
        sel = SEL_CONST; const_byte = ICMP_ECHO_REPLY;
      end else if (read_index_q == CW'(OFS_ICMP_CSUM_HI)) begin
        sel = SEL_CONST; const_byte = icmp_csum[15:8];
      end else if (read_index_q == CW'(OFS_ICMP_CSUM_LO)) begin
        sel = SEL_CONST; const_byte = icmp_csum[7:0];
      end
    end
  end

  always_comb begin
    byte_count_d = byte_count_q;
    read_index_d = read_index_q;
    hdr_sum_d    = hdr_sum_q;
    icmp_sum_d   = icmp_sum_q;
    v4_d         = v4_q;
    h20_d        = h20_q;
    trunc_d      = trunc_q;
    done_d       = done_q;
    emitting_d   = emitting_q;
    if (cmd_i.load) begin
      if (clr) begin
        read_index_d = '0;
        hdr_sum_d    = '0;
        icmp_sum_d   = '0;
        v4_d         = 1'b0;
        h20_d        = 1'b0;
        trunc_d      = 1'b0;
        done_d       = 1'b0;
        emitting_d   = 1'b0;
      end
      if (ld_idx == '0 && !trunc_d) begin
        v4_d  = is_ipv4_i;
        h20_d = (header_len_i == IPV4_MIN_HDR_LEN);
      end
      if (ld_idx < MaxCount) begin
        if (ld_idx < CW'(OFS_ICMP_TYPE)) begin
          if (ld_idx != CW'(OFS_IP_CSUM_HI) && ld_idx != CW'(OFS_IP_CSUM_LO)) begin
            hdr_sum_d = fold_add(hdr_sum_d, ld_word);
          end
        end else if (ld_idx != CW'(OFS_ICMP_TYPE) && ld_idx != CW'(OFS_ICMP_CSUM_HI) &&
                     ld_idx != CW'(OFS_ICMP_CSUM_LO)) begin
          icmp_sum_d = fold_add(icmp_sum_d, ld_word);
        end
        byte_count_d = ld_idx + CW'(1);
      end else begin
        trunc_d = 1'b1;
      end
      if (last_byte_i) begin
        done_d = 1'b1;
      end
    end else if (cmd_i.pull && hit) begin
      emitting_d = 1'b1;
      if (is_last) begin
        byte_count_d = '0;
        read_index_d = '0;
        hdr_sum_d    = '0;
        icmp_sum_d   = '0;
        v4_d         = 1'b0;
        h20_d        = 1'b0;
        trunc_d      = 1'b0;
        done_d       = 1'b0;
        emitting_d   = 1'b0;
      end else begin
        read_index_d = read_index_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      read_index_q <= '0;
      hdr_sum_q    <= '0;
      icmp_sum_q   <= '0;
      v4_q         <= 1'b0;
      h20_q        <= 1'b0;
      trunc_q      <= 1'b0;
      done_q       <= 1'b0;
      emitting_q   <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      read_index_q <= read_index_d;
      hdr_sum_q    <= hdr_sum_d;
      icmp_sum_q   <= icmp_sum_d;
      v4_q         <= v4_d;
      h20_q        <= h20_d;
      trunc_q      <= trunc_d;
      done_q       <= done_d;
      emitting_q   <= emitting_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ld_idx == CW'(OFS_ICMP_TYPE)) begin
      type_byte_q <= data_byte_i;
    end
    if (cmd_i.pull) begin
      p_hit_q   <= hit;
      p_last_q  <= is_last;
      p_rw_q    <= rw;
      p_trunc_q <= trunc_q;
      p_sel_q   <= sel;
      p_const_q <= const_byte;
    end
    if (cmd_i.capture) begin
      o_valid_q <= p_hit_q;
      o_last_q  <= p_hit_q && p_last_q;
      o_rw_q    <= p_hit_q && p_rw_q;
      o_trunc_q <= p_hit_q && p_trunc_q;
      if (!p_hit_q) begin
        o_byte_q <= 8'h00;
      end else if (p_sel_q == SEL_CONST) begin
        o_byte_q <= p_const_q;
      end else begin
        o_byte_q <= ram_rdata;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_byte_o  = o_byte_q;
  assign out_last_o  = o_last_q;
  assign rewritten_o = o_rw_q;
  assign truncated_o = o_trunc_q;

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= MaxCount)
    else $error("byte count beyond store size");

  ap_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_index_q < byte_count_q) || (read_index_q == '0))
    else $error("read index beyond loaded bytes");

  ap_emit_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting_q |-> done_q)
    else $error("read-out active without a complete packet");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the ICMP echo reply rewriter.
module tb_top;
  import icmprw_pkg::*;

  localparam int unsigned PKT_CAP      = 2048;
  localparam int unsigned RAND_ITEMS   = 630;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
    logic       rw;
    logic       trunc;
  } reply_t;

  typedef logic [7:0] pkt_bytes_t[$];

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       command_i;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       is_ipv4_i;
  logic [5:0] header_len_i;
  logic       res_valid_o;
  logic       res_ready_i;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       rewritten_o;
  logic       truncated_o;

  icmp_echo_reply_rewriter #(.MAX_PACKET(PKT_CAP)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic [7:0]  pkt_mem [PKT_CAP];
  int unsigned pkt_len;
  int unsigned rd_ptr;
  logic [15:0] hdr_acc;
  logic [15:0] icmp_acc;
  bit          f_v4, f_hdr20, f_trunc, f_done, draining;

  reply_t      replies_due[$];
  int unsigned items_sent = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct = 10;
  int unsigned stall_pct = 15;
  bit          calm = 1'b0;

  function automatic logic [15:0] ones_add(logic [15:0] acc, logic [15:0] w);
    int unsigned s;
    s = acc + w;
    s = (s & 32'hffff) + (s >> 16);
    return s[15:0];
  endfunction

  function automatic void clear_packet_state();
    pkt_len  = 0;
    rd_ptr   = 0;
    hdr_acc  = '0;
    icmp_acc = '0;
    f_v4     = 1'b0;
    f_hdr20  = 1'b0;
    f_trunc  = 1'b0;
    f_done   = 1'b0;
    draining = 1'b0;
  endfunction

  function automatic void store_byte(logic [7:0] b, logic lst, logic v4, logic [5:0] hl);
    logic [15:0] w;
    if (f_done || draining) clear_packet_state();
    if (pkt_len == 0 && !f_trunc) begin
      if (v4) f_v4 = 1'b1;
      if (hl == IPV4_MIN_HDR_LEN) f_hdr20 = 1'b1;
    end
    if (pkt_len < PKT_CAP) begin
      w = pkt_len[0] ? {8'h00, b} : {b, 8'h00};
      pkt_mem[pkt_len] = b;
      if (pkt_len < OFS_ICMP_TYPE) begin
        if (pkt_len != OFS_IP_CSUM_HI && pkt_len != OFS_IP_CSUM_LO)
          hdr_acc = ones_add(hdr_acc, w);
      end else if (pkt_len != OFS_ICMP_TYPE && pkt_len != OFS_ICMP_CSUM_HI &&
                   pkt_len != OFS_ICMP_CSUM_LO) begin
        icmp_acc = ones_add(icmp_acc, w);
      end
      pkt_len++;
    end else begin
      f_trunc = 1'b1;
    end
    if (lst) f_done = 1'b1;
  endfunction

  function automatic reply_t emit_byte();
    reply_t      r;
    int unsigned i;
    logic [15:0] hc, ic;
    bit          echo;
    r = '0;
    if (!f_done || rd_ptr >= pkt_len || rd_ptr >= PKT_CAP) return r;
    draining = 1'b1;
    i = rd_ptr;
    echo = f_v4 && f_hdr20 && !f_trunc && pkt_len >= ECHO_MIN_LEN &&
           pkt_mem[OFS_ICMP_TYPE] == ICMP_ECHO_REQUEST;
    r.data = pkt_mem[i];
    if (echo) begin
      hc = ~hdr_acc;
      ic = ~icmp_acc;
      if (i == OFS_IP_CSUM_HI) r.data = hc[15:8];
      else if (i == OFS_IP_CSUM_LO) r.data = hc[7:0];
      else if (i >= OFS_SRC_ADDR && i < OFS_DST_ADDR) r.data = pkt_mem[i + ADDR_BYTES];
      else if (i >= OFS_DST_ADDR && i < OFS_ICMP_TYPE) r.data = pkt_mem[i - ADDR_BYTES];
      else if (i == OFS_ICMP_TYPE) r.data = ICMP_ECHO_REPLY;
      else if (i == OFS_ICMP_CSUM_HI) r.data = ic[15:8];
      else if (i == OFS_ICMP_CSUM_LO) r.data = ic[7:0];
    end
    r.vld   = 1'b1;
    r.last  = (i + 1 == pkt_len);
    r.rw    = echo;
    r.trunc = f_trunc;
    if (r.last) clear_packet_state();
    else rd_ptr = i + 1;
    return r;
  endfunction

  task automatic log_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endtask

  // Drive one transaction and wait for it to be taken; called at a falling edge
  task automatic send_item(input logic cmd, input logic [7:0] b, input logic lst,
                           input logic v4, input logic [5:0] hl);
    command_i    <= cmd;
    data_byte_i  <= b;
    last_byte_i  <= lst;
    is_ipv4_i    <= v4;
    header_len_i <= hl;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CMD_LOAD) store_byte(b, lst, v4, hl);
    else replies_due.push_back(emit_byte());
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  // fill < 0 gives random content
  function automatic pkt_bytes_t make_packet(int unsigned len, int fill);
    pkt_bytes_t q;
    for (int unsigned k = 0; k < len; k++)
      q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    return q;
  endfunction

  // Family and header size only count on the first byte of a packet
  task automatic load_span(input pkt_bytes_t pkt, input int unsigned lo, input int unsigned hi,
                           input logic v4, input logic [5:0] hl, input bit mark_last);
    for (int unsigned k = lo; k < hi; k++) begin
      if (k == lo) send_item(CMD_LOAD, pkt[k], mark_last && k == hi - 1, v4, hl);
      else send_item(CMD_LOAD, pkt[k], mark_last && k == hi - 1,
                     1'($urandom_range(0, 1)), 6'($urandom_range(0, 60)));
      pause_sender();
    end
  endtask

  task automatic pull_n(input int unsigned n);
    repeat (n) begin
      send_item(CMD_PULL, 8'($urandom), 1'($urandom), 1'($urandom),
                6'($urandom_range(0, 60)));
      pause_sender();
    end
  endtask

  task automatic run_echo(input int unsigned len, input int unsigned extra);
    pkt_bytes_t pkt;
    pkt = make_packet(len, -1);
    pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REQUEST;
    load_span(pkt, 0, len, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
    pull_n(len + extra);
  endtask

  task automatic test_pull_without_packet();
    pkt_bytes_t pkt;
    pull_n(2);
    pkt = make_packet(4, -1);
    load_span(pkt, 0, 3, 1'b1, IPV4_MIN_HDR_LEN, 1'b0);
    pull_n(1);
    load_span(pkt, 3, 4, 1'b0, 6'd0, 1'b1);
    pull_n(5);
  endtask

  task automatic test_tiny_packets();
    pkt_bytes_t pkt;
    pkt = make_packet(1, 8'hff);
    load_span(pkt, 0, 1, 1'b1, 6'd60, 1'b1);
    pull_n(2);
    pkt = make_packet(1, 8'h00);
    load_span(pkt, 0, 1, 1'b0, 6'd0, 1'b1);
    pull_n(1);
  endtask

  task automatic test_echo_request();
    pkt_bytes_t pkt;
    // odd ICMP length, all ones elsewhere
    pkt = make_packet(29, 8'hff);
    pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REQUEST;
    load_span(pkt, 0, 29, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
    pull_n(30);
    pkt = make_packet(ECHO_MIN_LEN, 8'h00);
    pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REQUEST;
    load_span(pkt, 0, ECHO_MIN_LEN, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
    pull_n(ECHO_MIN_LEN);
    run_echo(40, 0);
  endtask

  task automatic test_not_echo();
    pkt_bytes_t pkt;
    pkt = make_packet(ECHO_MIN_LEN, -1);
    pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REQUEST;
    load_span(pkt, 0, ECHO_MIN_LEN, 1'b0, IPV4_MIN_HDR_LEN, 1'b1);
    pull_n(ECHO_MIN_LEN);
    load_span(pkt, 0, ECHO_MIN_LEN, 1'b1, 6'd23, 1'b1);
    pull_n(ECHO_MIN_LEN);
    load_span(pkt, 0, ECHO_MIN_LEN - 1, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
    pull_n(ECHO_MIN_LEN - 1);
    pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REPLY;
    load_span(pkt, 0, ECHO_MIN_LEN, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
    pull_n(ECHO_MIN_LEN);
  endtask

  task automatic test_packet_restart();
    pkt_bytes_t pkt;
    pkt = make_packet(30, -1);
    pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REQUEST;
    load_span(pkt, 0, 30, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
    pkt = make_packet(32, -1);
    pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REQUEST;
    load_span(pkt, 0, 32, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
    pull_n(5);
    run_echo(ECHO_MIN_LEN, 1);
  endtask

  task automatic test_random_traffic();
    int unsigned first, kind, len, cut;
    pkt_bytes_t  pkt;
    first = items_sent;
    while (items_sent - first < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      gap_pct = $urandom_range(0, 2) * 15;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(61, 300);
      else len = $urandom_range(ECHO_MIN_LEN, 60);
      pkt = make_packet(len, -1);
      pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REQUEST;
      if (kind < 60) begin
        load_span(pkt, 0, len, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
        pull_n(len + $urandom_range(0, 1));
      end else if (kind < 70) begin
        // near misses: wrong family, header size, type or length
        len = $urandom_range(1, 60);
        pkt = make_packet(len, -1);
        if (len > OFS_ICMP_TYPE && $urandom_range(0, 1))
          pkt[OFS_ICMP_TYPE] = ICMP_ECHO_REQUEST;
        load_span(pkt, 0, len, 1'($urandom_range(0, 1)),
                  $urandom_range(0, 1) ? IPV4_MIN_HDR_LEN : 6'($urandom_range(0, 60)), 1'b1);
        pull_n(len);
      end else if (kind < 80) begin
        // read-out cut short, the next load starts a new packet
        load_span(pkt, 0, len, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
        pull_n($urandom_range(1, len - 1));
      end else if (kind < 88) begin
        load_span(pkt, 0, len, 1'b1, IPV4_MIN_HDR_LEN, 1'b1);
      end else if (kind < 94) begin
        cut = $urandom_range(1, len - 1);
        load_span(pkt, 0, cut, 1'b1, IPV4_MIN_HDR_LEN, 1'b0);
        pull_n($urandom_range(1, 3));
        load_span(pkt, cut, len, 1'b0, 6'd0, 1'b1);
        pull_n(len);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 60)));
          pause_sender();
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    gap_pct = 0;
    repeat (4) run_echo($urandom_range(ECHO_MIN_LEN, 45), 1);
    run_echo(33, 0);
  endtask

  // Result side: stall bursts, with the stall rate drifting over the run
  initial begin
    res_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        res_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      res_ready_i <= 1'b1;
      if ($urandom_range(0, 199) == 0) stall_pct = $urandom_range(0, 2) * 15;
    end
  end

  always @(posedge clk_i) begin : reply_check
    reply_t got, want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      got = {out_valid_o, out_byte_o, out_last_o, rewritten_o, truncated_o};
      if (replies_due.size() == 0) begin
        log_failure($sformatf("unexpected result transaction: vld=%0d byte=%02h",
                              got.vld, got.data));
      end else begin
        want = replies_due.pop_front();
        if (got.vld !== want.vld || got.data !== want.data || got.last !== want.last ||
            got.rw !== want.rw || got.trunc !== want.trunc)
          log_failure($sformatf(
            "result mismatch: exp vld=%0d byte=%02h last=%0d rw=%0d trunc=%0d, %s",
            want.vld, want.data, want.last, want.rw, want.trunc,
            $sformatf("got vld=%0d byte=%02h last=%0d rw=%0d trunc=%0d",
                      got.vld, got.data, got.last, got.rw, got.trunc)));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (res_valid_o && res_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_valid_i   = 1'b0;
    command_i    = CMD_LOAD;
    data_byte_i  = '0;
    last_byte_i  = 1'b0;
    is_ipv4_i    = 1'b0;
    header_len_i = '0;
    rst_ni       = 1'b0;
    clear_packet_state();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_pull_without_packet();
    test_tiny_packets();
    test_echo_request();
    test_not_echo();
    test_packet_restart();
    test_random_traffic();
    test_back_to_back();

    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (replies_due.size() != 0) fail_cnt++;
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
src/icmprw_pkg.sv
src/icmprw_ram.sv
src/icmprw_ctrl.sv
src/icmprw_dp.sv
src/icmp_echo_reply_rewriter.sv
dv/tb_top.sv
